// File: rtl/avr_pkg.sv
// Shared types, constants and a rounding helper for the axis-angle rotation pipeline.
package avr_pkg;

   // Fixed formats of the axis and of the trigonometric values.
   localparam int AXIS_BITS  = 16;
   localparam int TRIG_W     = 16;   // rounded quarter sine, unsigned Q14
   localparam int SC_W       = 17;   // signed sine and cosine, Q14
   localparam int AA_W       = 32;   // product of two axis components
   localparam int SA_W       = 33;   // axis component times sine
   localparam int QSUM_W     = 48;   // matrix element before rounding, Q42
   localparam int EL_W       = 27;   // matrix element after rounding, Q20
   localparam int U_W        = 31;   // polynomial argument, unsigned Q30

   localparam logic [U_W-1:0] ONE_Q30 = 31'd1073741824;
   localparam logic signed [SC_W-1:0] ONE_Q14 = 17'sd16384;

   // Quarter-wave sine polynomial coefficients, unsigned Q30.
   localparam logic [30:0] POLY_A = 31'd1686629713;
   localparam logic [29:0] POLY_B = 30'd688904866;
   localparam logic [26:0] POLY_C = 27'd76016977;

   // Pipeline advance enables, one for each register stage.
   typedef struct packed {
      logic st8;
      logic st7;
      logic st6;
      logic st5;
      logic st4;
      logic st3;
      logic st2;
      logic st1;
   } stage_en_type;

   // Round half up from Q42 to Q20.
   function automatic logic signed [EL_W-1:0] round_element(
      input logic signed [QSUM_W-1:0] v);
      logic signed [QSUM_W-1:0] t;
      t = (v + 48'sd2097152) >>> 22;
      return t[EL_W-1:0];
   endfunction

endpackage

// File: rtl/axis_angle_vector_rotation_core.sv
// Top level of the axis-angle (Rodrigues) vector rotation pipeline.
//
//   Channel   Direction  Handshake              Word contents
//   req_      in         req_valid/req_ready    vector, turn angle, unit axis
//   rsp_      out        rsp_valid/rsp_ready    rotated vector, saturated
//
// The pipeline has eight register stages. A word accepted on req_ passes through
// all of them before it leaves on rsp_, and one word can be taken every cycle
// while rsp_ready does not stall the output. The depth is set by the four chained
// multiplies of the sine polynomial plus the matrix and product stages.
// Reset clears only the stage valid bits; the data registers are not reset.
// Each stage advances when it is empty or the stage after it advances, so a
// stall on rsp_ready lets bubbles fill up and req_ready drops only when every
// stage holds a word.
module axis_angle_vector_rotation_core #(
   parameter int ANGLE_BITS     = 16,
   parameter int COMPONENT_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [COMPONENT_BITS-1:0]      req_vec_x,
   input  logic signed [COMPONENT_BITS-1:0]      req_vec_y,
   input  logic signed [COMPONENT_BITS-1:0]      req_vec_z,
   input  logic [ANGLE_BITS-1:0]                 req_turn_angle,
   input  logic signed [avr_pkg::AXIS_BITS-1:0]  req_axis_x,
   input  logic signed [avr_pkg::AXIS_BITS-1:0]  req_axis_y,
   input  logic signed [avr_pkg::AXIS_BITS-1:0]  req_axis_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [COMPONENT_BITS-1:0]      rsp_rot_x,
   output logic signed [COMPONENT_BITS-1:0]      rsp_rot_y,
   output logic signed [COMPONENT_BITS-1:0]      rsp_rot_z
);

   localparam int NUM_STAGES = 8;
   localparam int FRAC_SHIFT = 32 - ANGLE_BITS;

   // Quadrant codes taken from the top two angle bits.
   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   logic [NUM_STAGES:1]              valid_ff;
   logic [NUM_STAGES:1]              en_v;
   avr_pkg::stage_en_type            en;

   quad_type                         quad_ff [1:4];
   logic signed [COMPONENT_BITS-1:0] vec_ff  [1:6][0:2];

   logic [29:0]                      frac_w;
   logic [avr_pkg::U_W-1:0]          u_sin_w, u_cos_w;
   logic [avr_pkg::TRIG_W-1:0]       sp_w, cp_w;
   logic signed [avr_pkg::SC_W-1:0]  sp_s, cp_s, sin_w, cos_w;
   logic signed [avr_pkg::EL_W-1:0]  elem_w [0:2][0:2];
   logic signed [COMPONENT_BITS-1:0] rot_w  [0:2];

   // Stage enables: stage k moves when empty or when stage k+1 moves.
   always_comb begin
      en_v[NUM_STAGES] = !valid_ff[NUM_STAGES] || rsp_ready;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         en_v[k] = !valid_ff[k] || en_v[k+1];
      end
   end

   assign en        = en_v;
   assign req_ready = en_v[1];
   assign rsp_valid = valid_ff[NUM_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en_v[1]) begin
            valid_ff[1] <= req_valid;
         end
         for (int k = 2; k <= NUM_STAGES; k++) begin
            if (en_v[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // The angle fraction below the quadrant bits, scaled to Q30, and its complement.
   assign frac_w  = 30'(req_turn_angle[ANGLE_BITS-3:0]) << FRAC_SHIFT;
   assign u_sin_w = {1'b0, frac_w};
   assign u_cos_w = avr_pkg::ONE_Q30 - u_sin_w;

   // The quadrant and the vector ride alongside the trig and matrix stages.
   always_ff @(posedge clock) begin
      if (en_v[1]) begin
         quad_ff[1]   <= quad_type'(req_turn_angle[ANGLE_BITS-1:ANGLE_BITS-2]);
         vec_ff[1][0] <= req_vec_x;
         vec_ff[1][1] <= req_vec_y;
         vec_ff[1][2] <= req_vec_z;
      end
      for (int k = 2; k <= 4; k++) begin
         if (en_v[k]) begin
            quad_ff[k] <= quad_ff[k-1];
         end
      end
      for (int k = 2; k <= 6; k++) begin
         if (en_v[k]) begin
            vec_ff[k] <= vec_ff[k-1];
         end
      end
   end

   avr_qsine u_sine (
      .clock (clock),
      .en    (en),
      .u     (u_sin_w),
      .sine  (sp_w)
   );

   avr_qsine u_cosine (
      .clock (clock),
      .en    (en),
      .u     (u_cos_w),
      .sine  (cp_w)
   );

   // Map the first-quadrant values to the full circle.
   assign sp_s = $signed({1'b0, sp_w});
   assign cp_s = $signed({1'b0, cp_w});

   always_comb begin
      unique case (quad_ff[4])
         QUAD_0: begin
            sin_w = sp_s;
            cos_w = cp_s;
         end
         QUAD_1: begin
            sin_w = cp_s;
            cos_w = -sp_s;
         end
         QUAD_2: begin
            sin_w = -sp_s;
            cos_w = -cp_s;
         end
         QUAD_3: begin
            sin_w = -cp_s;
            cos_w = sp_s;
         end
         default: begin
            sin_w = sp_s;
            cos_w = cp_s;
         end
      endcase
   end

   avr_matrix u_matrix (
      .clock  (clock),
      .en     (en),
      .axis_x (req_axis_x),
      .axis_y (req_axis_y),
      .axis_z (req_axis_z),
      .sin_v  (sin_w),
      .cos_v  (cos_w),
      .elem   (elem_w)
   );

   avr_apply #(
      .COMPONENT_BITS (COMPONENT_BITS)
   ) u_apply (
      .clock (clock),
      .en    (en),
      .elem  (elem_w),
      .vec   (vec_ff[6]),
      .rot   (rot_w)
   );

   assign rsp_rot_x = rot_w[0];
   assign rsp_rot_y = rot_w[1];
   assign rsp_rot_z = rot_w[2];

   // The input is refused only when every stage holds a word.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&valid_ff))
      else $error("input refused while the pipeline has an empty stage");

   // The quarter sine never exceeds one in Q14.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[4] |-> (sp_w <= 16'd16384) && (cp_w <= 16'd16384))
      else $error("quarter sine out of range");

   // A stalled output holds the word behind it in place.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[8] && !rsp_ready && valid_ff[7]) |=> (valid_ff[7] && valid_ff[8]))
      else $error("word lost behind a stalled output");

endmodule

// File: rtl/avr_qsine.sv
// Four-stage quarter-wave sine polynomial, unsigned Q30 in, rounded Q14 out.
module avr_qsine (
   input  logic                          clock,
   input  avr_pkg::stage_en_type         en,
   input  logic [avr_pkg::U_W-1:0]       u,
   output logic [avr_pkg::TRIG_W-1:0]    sine
);

   logic [avr_pkg::U_W-1:0] u1_ff, u2_ff, u3_ff;
   logic [avr_pkg::U_W-1:0] sq1_ff, sq2_ff;
   logic [29:0]             t2_ff;
   logic [30:0]             t3_ff;
   logic [avr_pkg::TRIG_W-1:0] sine_ff;

   logic [61:0] sq_w;
   logic [57:0] m1_w;
   logic [60:0] m2_w;
   logic [61:0] m3_w;
   logic [31:0] rnd_w;

   assign sq_w  = 62'(u) * 62'(u);
   assign m1_w  = 58'(sq1_ff) * 58'(avr_pkg::POLY_C);
   assign m2_w  = 61'(sq2_ff) * 61'(t2_ff);
   assign m3_w  = 62'(u3_ff) * 62'(t3_ff);
   assign rnd_w = 32'(m3_w[61:30]) + 32'd32768;

   always_ff @(posedge clock) begin
      if (en.st1) begin
         u1_ff  <= u;
         sq1_ff <= sq_w[60:30];
      end
      if (en.st2) begin
         u2_ff  <= u1_ff;
         sq2_ff <= sq1_ff;
         t2_ff  <= avr_pkg::POLY_B - 30'(m1_w[57:30]);
      end
      if (en.st3) begin
         u3_ff <= u2_ff;
         t3_ff <= avr_pkg::POLY_A - m2_w[60:30];
      end
      if (en.st4) begin
         sine_ff <= rnd_w[31:16];
      end
   end

   assign sine = sine_ff;

endmodule

// File: rtl/avr_matrix.sv
// Rotation matrix stages: axis products, scaling by sine and cosine, rounding to Q20.
module avr_matrix (
   input  logic                                   clock,
   input  avr_pkg::stage_en_type                  en,
   input  logic signed [avr_pkg::AXIS_BITS-1:0]   axis_x,
   input  logic signed [avr_pkg::AXIS_BITS-1:0]   axis_y,
   input  logic signed [avr_pkg::AXIS_BITS-1:0]   axis_z,
   input  logic signed [avr_pkg::SC_W-1:0]        sin_v,
   input  logic signed [avr_pkg::SC_W-1:0]        cos_v,
   output logic signed [avr_pkg::EL_W-1:0]        elem [0:2][0:2]
);

   // Axis products in the order xx, yy, zz, xy, xz, yz.
   logic signed [avr_pkg::AA_W-1:0]      aa_ff   [1:4][0:5];
   logic signed [avr_pkg::AXIS_BITS-1:0] ax_ff   [1:4][0:2];
   logic signed [avr_pkg::QSUM_W-1:0]    pq_ff   [0:5];
   logic signed [avr_pkg::SA_W-1:0]      sa_ff   [0:2];
   logic signed [avr_pkg::SC_W-1:0]      c5_ff;
   logic signed [avr_pkg::EL_W-1:0]      elem_ff [0:2][0:2];

   logic signed [avr_pkg::SC_W-1:0]      omc_w;
   logic signed [avr_pkg::QSUM_W-1:0]    cd_w;
   logic signed [avr_pkg::QSUM_W-1:0]    sk_w [0:2];

   assign omc_w = avr_pkg::ONE_Q14 - cos_v;
   assign cd_w  = avr_pkg::QSUM_W'(c5_ff) <<< 28;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sk_w[k] = avr_pkg::QSUM_W'(sa_ff[k]) <<< 14;
      end
   end

   always_ff @(posedge clock) begin
      if (en.st1) begin
         aa_ff[1][0] <= avr_pkg::AA_W'(axis_x) * avr_pkg::AA_W'(axis_x);
         aa_ff[1][1] <= avr_pkg::AA_W'(axis_y) * avr_pkg::AA_W'(axis_y);
         aa_ff[1][2] <= avr_pkg::AA_W'(axis_z) * avr_pkg::AA_W'(axis_z);
         aa_ff[1][3] <= avr_pkg::AA_W'(axis_x) * avr_pkg::AA_W'(axis_y);
         aa_ff[1][4] <= avr_pkg::AA_W'(axis_x) * avr_pkg::AA_W'(axis_z);
         aa_ff[1][5] <= avr_pkg::AA_W'(axis_y) * avr_pkg::AA_W'(axis_z);
         ax_ff[1][0] <= axis_x;
         ax_ff[1][1] <= axis_y;
         ax_ff[1][2] <= axis_z;
      end
      if (en.st2) begin
         aa_ff[2] <= aa_ff[1];
         ax_ff[2] <= ax_ff[1];
      end
      if (en.st3) begin
         aa_ff[3] <= aa_ff[2];
         ax_ff[3] <= ax_ff[2];
      end
      if (en.st4) begin
         aa_ff[4] <= aa_ff[3];
         ax_ff[4] <= ax_ff[3];
      end
      if (en.st5) begin
         for (int k = 0; k < 6; k++) begin
            pq_ff[k] <= avr_pkg::QSUM_W'(aa_ff[4][k]) * avr_pkg::QSUM_W'(omc_w);
         end
         for (int k = 0; k < 3; k++) begin
            sa_ff[k] <= avr_pkg::SA_W'(ax_ff[4][k]) * avr_pkg::SA_W'(sin_v);
         end
         c5_ff <= cos_v;
      end
      if (en.st6) begin
         elem_ff[0][0] <= avr_pkg::round_element(cd_w + pq_ff[0]);
         elem_ff[0][1] <= avr_pkg::round_element(pq_ff[3] - sk_w[2]);
         elem_ff[0][2] <= avr_pkg::round_element(pq_ff[4] + sk_w[1]);
         elem_ff[1][0] <= avr_pkg::round_element(pq_ff[3] + sk_w[2]);
         elem_ff[1][1] <= avr_pkg::round_element(cd_w + pq_ff[1]);
         elem_ff[1][2] <= avr_pkg::round_element(pq_ff[5] - sk_w[0]);
         elem_ff[2][0] <= avr_pkg::round_element(pq_ff[4] - sk_w[1]);
         elem_ff[2][1] <= avr_pkg::round_element(pq_ff[5] + sk_w[0]);
         elem_ff[2][2] <= avr_pkg::round_element(cd_w + pq_ff[2]);
      end
   end

   assign elem = elem_ff;

endmodule

// File: rtl/avr_apply.sv
// Matrix-vector product stages with final rounding and saturation.
module avr_apply #(
   parameter int COMPONENT_BITS = 16
) (
   input  logic                               clock,
   input  avr_pkg::stage_en_type              en,
   input  logic signed [avr_pkg::EL_W-1:0]    elem [0:2][0:2],
   input  logic signed [COMPONENT_BITS-1:0]   vec  [0:2],
   output logic signed [COMPONENT_BITS-1:0]   rot  [0:2]
);

   localparam int PW = avr_pkg::EL_W + COMPONENT_BITS;
   localparam int AW = PW + 2;
   localparam logic signed [AW-1:0] HI = AW'((64'sd1 <<< (COMPONENT_BITS - 1)) - 64'sd1);
   localparam logic signed [AW-1:0] LO = -HI - AW'(1);
   localparam logic signed [AW-1:0] HALF = AW'(64'sd524288);

   logic signed [PW-1:0]             prod_ff [0:2][0:2];
   logic signed [COMPONENT_BITS-1:0] rot_ff  [0:2];
   logic signed [AW-1:0]             sum_w   [0:2];
   logic signed [AW-1:0]             rnd_w   [0:2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_w[i] = AW'(prod_ff[i][0]) + AW'(prod_ff[i][1]) + AW'(prod_ff[i][2]);
         rnd_w[i] = (sum_w[i] + HALF) >>> 20;
      end
   end

   always_ff @(posedge clock) begin
      if (en.st7) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[i][j] <= PW'(elem[i][j]) * PW'(vec[j]);
            end
         end
      end
      if (en.st8) begin
         for (int i = 0; i < 3; i++) begin
            if (rnd_w[i] > HI) begin
               rot_ff[i] <= HI[COMPONENT_BITS-1:0];
            end else if (rnd_w[i] < LO) begin
               rot_ff[i] <= LO[COMPONENT_BITS-1:0];
            end else begin
               rot_ff[i] <= rnd_w[i][COMPONENT_BITS-1:0];
            end
         end
      end
   end

   assign rot = rot_ff;

endmodule
